>>> hdl/bpq_pkg.sv
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants for the button press queue: item and register
// codes, reset values of the direction registers and the cell control bundle.
// ----------------------------------------------------------------------------
package bpq_pkg;

  // Default capacity of each player's queue.
  localparam int QUEUE_DEPTH_DEFAULT = 8;

  // Width of a direction code.
  localparam int CODE_W = 2;

  // Number of direction buttons per player.
  localparam int NUM_DIRS = 4;

  // Item functions.
  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_UP    = 2'd0;
  localparam logic [1:0] REG_DOWN  = 2'd1;
  localparam logic [1:0] REG_LEFT  = 2'd2;
  localparam logic [1:0] REG_RIGHT = 2'd3;

  // Reset values of the direction registers.
  localparam logic [CODE_W-1:0] UP_RESET    = 2'd0;
  localparam logic [CODE_W-1:0] DOWN_RESET  = 2'd1;
  localparam logic [CODE_W-1:0] LEFT_RESET  = 2'd2;
  localparam logic [CODE_W-1:0] RIGHT_RESET = 2'd3;

  // Control for one storage cell of a queue.
  typedef struct packed {
    logic              shift;
    logic              load;
    logic [CODE_W-1:0] code;
  } cell_ctrl_t;

endpackage

>>> hdl/bpq_cell.sv
// ----------------------------------------------------------------------------
// bpq_cell
// One entry of a queue. It takes its neighbor's code when the queue pops and
// a new code when a push lands on it.
// ----------------------------------------------------------------------------
module bpq_cell (
  input  logic                        clk,
  input  bpq_pkg::cell_ctrl_t         ctrl,
  input  logic [bpq_pkg::CODE_W-1:0]  from_next,
  output logic [bpq_pkg::CODE_W-1:0]  data
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      data <= from_next;
    end else if (ctrl.load) begin
      data <= ctrl.code;
    end
  end

endmodule

>>> hdl/bpq_queue.sv
// ----------------------------------------------------------------------------
// bpq_queue
// One player's queue: a chain of cells with the head in cell 0, a fill count
// and a copy of the tail code for the repeat-press check.
// ----------------------------------------------------------------------------
module bpq_queue #(
  parameter int QUEUE_DEPTH = bpq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              scan,
  input  logic                                              pop,
  input  logic [bpq_pkg::NUM_DIRS-1:0]                      nibble,
  input  logic [bpq_pkg::NUM_DIRS-1:0][bpq_pkg::CODE_W-1:0] push_codes,
  output logic [bpq_pkg::CODE_W-1:0]                        head,
  output logic [CW-1:0]                                     count
);

  logic [bpq_pkg::CODE_W-1:0] cell_data [QUEUE_DEPTH];
  logic [bpq_pkg::NUM_DIRS-1:0] acc;
  logic [CW-1:0] pos [bpq_pkg::NUM_DIRS];
  logic [CW-1:0] count_next;
  logic [CW-1:0] scan_count;
  logic [bpq_pkg::CODE_W-1:0] tail;
  logic [bpq_pkg::CODE_W-1:0] tail_next;
  logic [bpq_pkg::CODE_W-1:0] scan_tail;
  logic do_pop;

  assign do_pop = pop && (count != '0);
  assign head   = cell_data[0];

  // Walk the four directions in order; each accepted push moves the tail.
  always_comb begin
    logic [CW-1:0] n;
    logic [bpq_pkg::CODE_W-1:0] t;
    logic [bpq_pkg::CODE_W-1:0] c;
    n = count;
    t = tail;
    for (int k = 0; k < bpq_pkg::NUM_DIRS; k++) begin
      c      = push_codes[k];
      pos[k] = n;
      acc[k] = scan && !nibble[c] && (n < CW'(QUEUE_DEPTH)) &&
               !((n != '0) && (t == c));
      if (acc[k]) begin
        t = c;
        n = n + CW'(1);
      end
    end
    scan_count = n;
    scan_tail  = t;
  end

  always_comb begin
    if (do_pop) begin
      count_next = count - CW'(1);
    end else if (scan) begin
      count_next = scan_count;
    end else begin
      count_next = count;
    end
    tail_next = scan ? scan_tail : tail;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The tail copy is only consulted while the count is nonzero.
  always_ff @(posedge clk) begin
    tail <= tail_next;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    bpq_pkg::cell_ctrl_t ctrl;
    logic [bpq_pkg::CODE_W-1:0] from_next;

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign from_next = '0;
    end else begin : g_mid
      assign from_next = cell_data[i+1];
    end

    always_comb begin
      ctrl.shift = do_pop;
      ctrl.load  = 1'b0;
      ctrl.code  = push_codes[0];
      for (int k = 0; k < bpq_pkg::NUM_DIRS; k++) begin
        if (acc[k] && (pos[k] == CW'(i))) begin
          ctrl.load = 1'b1;
          ctrl.code = push_codes[k];
        end
      end
    end

    bpq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .from_next (from_next),
      .data      (cell_data[i])
    );
  end

endmodule

>>> hdl/button_press_queue.sv
// ----------------------------------------------------------------------------
// button_press_queue
// Two per-player queues of direction-button presses fed by button scans and
// drained one entry per take transaction.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless its input is
// stalled. A scan transaction carries an active-low button byte (player 0
// in bits 7:4, player 1 in bits 3:0); if the byte differs from the last one
// that was acted on, every pressed button of each player is pushed in the
// order up, down, left, right, skipping a push that repeats the queue's tail
// and any push once the queue is full. All four pushes of both players
// complete in the same cycle, so a scan produces no result and is finished
// when it is accepted. A take transaction pops the head of the selected
// player's queue and its result is registered in the output register. Each
// queue is a chain of storage cells with the head in the first cell; a pop
// shifts every cell one place toward the head. The input is stalled only
// while a result waits in the output register and the downstream side is
// stalling it. The direction registers are written through the plain write
// port and should only change while the block is idle.
// ----------------------------------------------------------------------------
module button_press_queue #(
  parameter int QUEUE_DEPTH = bpq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  button_byte,
  input  logic        player,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        has_button,
  output logic [1:0]  button_code,
  output logic [3:0]  entries_left,
  // Configuration write port.
  input  logic        write_enable,
  input  logic [1:0]  reg_index,
  input  logic [1:0]  write_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [bpq_pkg::CODE_W-1:0] up_bit;
  logic [bpq_pkg::CODE_W-1:0] down_bit;
  logic [bpq_pkg::CODE_W-1:0] left_bit;
  logic [bpq_pkg::CODE_W-1:0] right_bit;
  logic [7:0] previous_byte;

  logic in_accept;
  logic scan_go;
  logic take_go;
  logic [bpq_pkg::NUM_DIRS-1:0][bpq_pkg::CODE_W-1:0] push_codes;
  logic [bpq_pkg::CODE_W-1:0] head0;
  logic [bpq_pkg::CODE_W-1:0] head1;
  logic [CW-1:0] count0;
  logic [CW-1:0] count1;
  logic [bpq_pkg::CODE_W-1:0] sel_head;
  logic [CW-1:0] sel_count;

  // A new transaction is held off only while a finished result is stalled.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  // A scan whose byte matches the previous one changes nothing at all.
  assign scan_go = in_accept && (func == bpq_pkg::FUNC_SCAN) &&
                   (button_byte != previous_byte);
  assign take_go = in_accept && (func == bpq_pkg::FUNC_TAKE);

  // Push order is up, down, left, right; each code is also its bit index.
  assign push_codes[0] = up_bit;
  assign push_codes[1] = down_bit;
  assign push_codes[2] = left_bit;
  assign push_codes[3] = right_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      up_bit    <= bpq_pkg::UP_RESET;
      down_bit  <= bpq_pkg::DOWN_RESET;
      left_bit  <= bpq_pkg::LEFT_RESET;
      right_bit <= bpq_pkg::RIGHT_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        bpq_pkg::REG_UP:    up_bit    <= write_data;
        bpq_pkg::REG_DOWN:  down_bit  <= write_data;
        bpq_pkg::REG_LEFT:  left_bit  <= write_data;
        bpq_pkg::REG_RIGHT: right_bit <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_byte <= '0;
    end else if (scan_go) begin
      previous_byte <= button_byte;
    end
  end

  bpq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue0 (
    .clk        (clk),
    .rst        (rst),
    .scan       (scan_go),
    .pop        (take_go && (player == 1'b0)),
    .nibble     (button_byte[7:4]),
    .push_codes (push_codes),
    .head       (head0),
    .count      (count0)
  );

  bpq_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue1 (
    .clk        (clk),
    .rst        (rst),
    .scan       (scan_go),
    .pop        (take_go && (player == 1'b1)),
    .nibble     (button_byte[3:0]),
    .push_codes (push_codes),
    .head       (head1),
    .count      (count1)
  );

  assign sel_head  = player ? head1 : head0;
  assign sel_count = player ? count1 : count0;

  // Output register: loaded by a take, emptied when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // An empty queue reports zeros in every field.
  always_ff @(posedge clk) begin
    if (take_go) begin
      if (sel_count != '0) begin
        has_button   <= 1'b1;
        button_code  <= sel_head;
        entries_left <= 4'(sel_count - CW'(1));
      end else begin
        has_button   <= 1'b0;
        button_code  <= '0;
        entries_left <= '0;
      end
    end
  end

endmodule

>>> hdl/bpq_checker.sv
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the button press queue, bound to the top level.
// ----------------------------------------------------------------------------
module bpq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       func,
  input logic       out_valid,
  input logic       out_stall,
  input logic       has_button,
  input logic [1:0] button_code,
  input logic [3:0] entries_left
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(has_button) && $stable(button_code) &&
      $stable(entries_left))
    else $error("stalled result changed");

  // Every accepted take shows its result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == bpq_pkg::FUNC_TAKE) |=> out_valid)
    else $error("take produced no result");

  // A scan produces no result.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == bpq_pkg::FUNC_SCAN) |=> !out_valid)
    else $error("scan produced a result");

  // An empty take reports zeros.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_button |-> (button_code == 2'd0) && (entries_left == 4'd0))
    else $error("empty take has nonzero fields");

endmodule

bind button_press_queue bpq_checker u_bpq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .func         (func),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .has_button   (has_button),
  .button_code  (button_code),
  .entries_left (entries_left)
);

>>> tb/button_press_queue_tb.sv
// ----------------------------------------------------------------------------
// button_press_queue_tb
// Self-checking testbench for the per-player button press queues. It drives
// scan and take transactions through the valid/stall channel, predicts every
// take result with its own model of both queues, and compares each result
// field by field. It covers directed corner cases, several direction
// mappings, random traffic under varied idling, and a long output hold-off
// that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module button_press_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = bpq_pkg::QUEUE_DEPTH_DEFAULT;

  // One expected take result, laid out like the result ports.
  typedef struct packed {
    logic       has_button;
    logic [1:0] code;
    logic [3:0] left;
  } take_result_t;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       func = bpq_pkg::FUNC_SCAN;
  logic [7:0] button_byte = 8'h00;
  logic       player = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       has_button;
  logic [1:0] button_code;
  logic [3:0] entries_left;
  logic       write_enable = 1'b0;
  logic [1:0] reg_index = bpq_pkg::REG_UP;
  logic [1:0] write_data = 2'd0;

  // Our own copy of the block's state: both queues with the head in slot 0,
  // the entry counts, the last byte that was acted on and the direction map.
  logic [1:0]   press_codes [2][DEPTH];
  int           press_count [2] = '{0, 0};
  logic [7:0]   last_scan_byte = 8'h00;
  logic [1:0]   dir_code [bpq_pkg::NUM_DIRS] = '{bpq_pkg::UP_RESET, bpq_pkg::DOWN_RESET,
                                                 bpq_pkg::LEFT_RESET, bpq_pkg::RIGHT_RESET};

  // Take results that the block still owes us, oldest first.
  take_result_t expected_takes [$];

  // Idling controls shared by the sender and the downstream process.
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int fail_count = 0;

  button_press_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .button_byte  (button_byte),
    .player       (player),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .has_button   (has_button),
    .button_code  (button_code),
    .entries_left (entries_left),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  always #2 clk = ~clk;

  // Any failure goes through here; only the first ten are printed in full.
  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endfunction

  // Applies one accepted transaction to our copy of the queues. A scan with
  // a new byte pushes every pressed direction of player 0 and then player 1
  // in the order up, down, left, right. A push is dropped when the queue is
  // full or when it would repeat the tail entry. Note that two directions
  // mapped to the same bit are each tested on that bit and pushed with their
  // own code. A take pops the head, or yields an all-zero result when the
  // queue is empty, and queues the result we expect to see.
  function automatic void update_press_queues(input logic f, input logic [7:0] b,
                                              input logic p);
    logic [3:0]   nib;
    logic [1:0]   code;
    int           n;
    take_result_t res;
    if (f == bpq_pkg::FUNC_SCAN) begin
      if (b == last_scan_byte) return;
      for (int pl = 0; pl < 2; pl++) begin
        nib = (pl == 0) ? b[7:4] : b[3:0];
        for (int d = 0; d < bpq_pkg::NUM_DIRS; d++) begin
          code = dir_code[d];
          n = press_count[pl];
          // Buttons are active low, so a zero bit means pressed.
          if (!nib[code] && n < DEPTH && !(n > 0 && press_codes[pl][n-1] == code)) begin
            press_codes[pl][n] = code;
            press_count[pl] = n + 1;
          end
        end
      end
      last_scan_byte = b;
    end else begin
      res = '0;
      n = press_count[p];
      if (n > 0) begin
        res.has_button = 1'b1;
        res.code = press_codes[p][0];
        for (int i = 0; i < DEPTH - 1; i++) press_codes[p][i] = press_codes[p][i+1];
        press_count[p] = n - 1;
        res.left = 4'(n - 1);
      end
      expected_takes.push_back(res);
    end
  endfunction

  // Sends one transaction. It is called just after a falling edge, may idle
  // first, then holds the payload steady until the block accepts it at a
  // rising edge, and returns at the next falling edge with valid still high
  // so that back-to-back transactions follow one another without a gap.
  task automatic send_item(input logic f, input logic [7:0] b, input logic p);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    button_byte <= b;
    player      <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_press_queues(f, b, p);
    @(negedge clk);
  endtask

  // Lowers valid and waits until every owed result has arrived, then lets the
  // clock run on so that the block is surely idle. Anything still owed after
  // the bound is a lost result and is reported here.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (expected_takes.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (expected_takes.size() != 0) begin
      note_failure($sformatf("%0d take results never arrived", expected_takes.size()));
      expected_takes.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_dir(input logic [1:0] idx, input logic [1:0] value);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= value;
    dir_code[idx] = value;
    @(negedge clk);
  endtask

  // Rewrites the whole direction map; only called while the block is idle.
  task automatic set_directions(input logic [1:0] u, input logic [1:0] d,
                                input logic [1:0] l, input logic [1:0] r);
    wait_idle();
    write_dir(bpq_pkg::REG_UP, u);
    write_dir(bpq_pkg::REG_DOWN, d);
    write_dir(bpq_pkg::REG_LEFT, l);
    write_dir(bpq_pkg::REG_RIGHT, r);
    write_enable <= 1'b0;
  endtask

  // Random traffic. The share of takes swings between low and high every
  // twenty transactions so the queues both fill up and run dry. Some scans
  // repeat the last byte on purpose to exercise the ignored-scan path.
  task automatic run_traffic(input int count);
    int         take_pct;
    logic [7:0] b;
    for (int k = 0; k < count; k++) begin
      take_pct = ((k / 20) % 2 == 1) ? 65 : 30;
      if ($urandom_range(99, 0) < take_pct) begin
        send_item(bpq_pkg::FUNC_TAKE, 8'($urandom), 1'($urandom));
      end else begin
        b = ($urandom_range(9, 0) == 0) ? last_scan_byte : 8'($urandom);
        send_item(bpq_pkg::FUNC_SCAN, b, 1'($urandom));
      end
    end
  endtask

  // Directed corner cases with the reset direction map: empty takes, the
  // ignored first zero byte, unchanged bytes, repeat presses, full queues
  // with later pushes of the same scan dropped too, and a complete drain.
  task automatic test_queue_basics();
    send_item(bpq_pkg::FUNC_TAKE, 8'h00, 1'b0);
    send_item(bpq_pkg::FUNC_TAKE, 8'hFF, 1'b1);
    send_item(bpq_pkg::FUNC_SCAN, 8'h00, 1'b0);
    send_item(bpq_pkg::FUNC_SCAN, 8'hFF, 1'b1);
    send_item(bpq_pkg::FUNC_SCAN, 8'h00, 1'b0);
    send_item(bpq_pkg::FUNC_SCAN, 8'h00, 1'b1);
    send_item(bpq_pkg::FUNC_TAKE, 8'h00, 1'b0);
    send_item(bpq_pkg::FUNC_TAKE, 8'h00, 1'b1);
    send_item(bpq_pkg::FUNC_SCAN, 8'hEE, 1'b0);
    send_item(bpq_pkg::FUNC_SCAN, 8'hEF, 1'b0);
    send_item(bpq_pkg::FUNC_SCAN, 8'h0F, 1'b1);
    send_item(bpq_pkg::FUNC_SCAN, 8'hF0, 1'b0);
    send_item(bpq_pkg::FUNC_SCAN, 8'h00, 1'b1);
    send_item(bpq_pkg::FUNC_SCAN, 8'hFF, 1'b0);
    send_item(bpq_pkg::FUNC_SCAN, 8'h00, 1'b0);
    repeat (DEPTH + 1) send_item(bpq_pkg::FUNC_TAKE, 8'h5A, 1'b0);
    send_item(bpq_pkg::FUNC_TAKE, 8'hA5, 1'b1);
  endtask

  // Several direction maps, including every register at its lowest and at
  // its highest value, where all four buttons share one bit.
  task automatic test_direction_mapping();
    logic [1:0] maps [4][bpq_pkg::NUM_DIRS];
    maps = '{'{2'd0, 2'd0, 2'd0, 2'd0}, '{2'd3, 2'd3, 2'd3, 2'd3},
             '{2'd3, 2'd2, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd3, 2'd3}};
    for (int m = 0; m < 4; m++) begin
      set_directions(maps[m][0], maps[m][1], maps[m][2], maps[m][3]);
      send_item(bpq_pkg::FUNC_SCAN, 8'h00, 1'b0);
      send_item(bpq_pkg::FUNC_SCAN, 8'h77, 1'b1);
      run_traffic(25);
    end
    set_directions(bpq_pkg::UP_RESET, bpq_pkg::DOWN_RESET,
                   bpq_pkg::LEFT_RESET, bpq_pkg::RIGHT_RESET);
  endtask

  // Random traffic in four idling phases; the first uses the reset map and
  // each later one a fresh random map.
  task automatic test_idling_phases();
    int gaps [4]   = '{0, 86, 0, 15};
    int stalls [4] = '{0, 0, 86, 15};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        set_directions(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
      end
      gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      run_traffic(110);
    end
    gap_pct = 0;
    stall_pct = 0;
  endtask

  // The downstream side holds off for a long stretch while the sender keeps
  // offering takes and scans, so the output register fills and the block
  // has to stall its input until the hold ends.
  task automatic test_full_backpressure();
    hold_cycles = 100;
    run_traffic(40);
    wait (hold_cycles == 0);
  endtask

  // Downstream stall driver. A requested hold keeps stall high until the hold
  // has run down; otherwise stall follows the current random percentage.
  initial begin : downstream
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else begin
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
    end
  end

  // Checks every result transaction against the oldest expectation.
  always @(posedge clk) begin : result_check
    take_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_takes.size() == 0) begin
        note_failure("result transaction arrived with no take outstanding");
      end else begin
        want = expected_takes.pop_front();
        if (has_button !== want.has_button)
          note_failure($sformatf("has_button expected %0d got %0d",
                                 want.has_button, has_button));
        if (button_code !== want.code)
          note_failure($sformatf("button_code expected %0d got %0d",
                                 want.code, button_code));
        if (entries_left !== want.left)
          note_failure($sformatf("entries_left expected %0d got %0d",
                                 want.left, entries_left));
      end
    end
  end

  // Main sequence: hold reset, run each test in turn, drain and report.
  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_queue_basics();
    test_direction_mapping();
    test_idling_phases();
    test_full_backpressure();
    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
